[design/docr_pkg.sv]
// Package for the dissolved-oxygen compensated reading block.
// Holds the FSM state, command and status types, register codes and the
// constant saturation and water-vapor lookup tables. No dependencies.
package docr_pkg;

    // Averaging and table limits
    localparam int MAX_AVERAGE  = 255;
    localparam int TABLE_POINTS = 41;
    localparam int TABLE_LAST   = TABLE_POINTS - 1;

    // Shared divider widths: dividend and divisor
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW);

    // Sea-level pressure in 0.0001 hPa, probe slope in 0.01 mV per 0.01 degC
    localparam logic [23:0] SEA_LEVEL_P100 = 24'd10132500;
    localparam int          SLOPE_PER_DEG  = 35;

    // Valid ranges of temperature and pressure for compensation
    localparam int TEMP_MAX = 4000;
    localparam int AIR_MIN  = 50000;
    localparam int AIR_MAX  = 110000;

    // Reciprocal of 100 for the whole-degree split (t * 5243 >> 19)
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_SHFT = 19;

    // Output saturation limits
    localparam logic [47:0] DO_POS_LIM = 48'd524287;
    localparam logic [47:0] DO_NEG_LIM = 48'd524288;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CALIBRATED     = 3'd0,
        REG_SAT_MILLIVOLTS = 3'd1,
        REG_CAL_TEMP       = 3'd2,
        REG_AIR_PRESSURE   = 3'd3,
        REG_AVERAGE_COUNT  = 3'd4
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NO_CAL = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_SLOPE  = 2'd3
    } status_t;

    // Divider operand selection
    typedef enum logic [1:0] {
        DIV_AVG = 2'd0,
        DIV_SAT = 2'd1,
        DIV_DO  = 2'd2
    } div_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_AVG_WAIT,
        ST_LO,
        ST_FRAC,
        ST_INTERP,
        ST_DRY,
        ST_MUL,
        ST_SAT,
        ST_SAT_WAIT,
        ST_MUL3,
        ST_DOV,
        ST_DOV_WAIT,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     ld_avg;
        logic     ld_lo;
        logic     ld_frac;
        logic     ld_interp;
        logic     ld_dry;
        logic     ld_mul;
        logic     ld_sat;
        logic     ld_mul3;
        logic     ld_do;
        logic     ld_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic grp_end;
        logic stat_ok;
        logic div_done;
        logic out_busy;
    } sts_t;

    // Sea-level oxygen saturation in ug/L (0.001 mg/L), per whole degC
    function automatic logic [13:0] sat_lookup(input logic [5:0] idx);
        logic [13:0] v;
        case (idx)
            6'd0:  v = 14'd14460;  6'd1:  v = 14'd14220;  6'd2:  v = 14'd13820;
            6'd3:  v = 14'd13440;  6'd4:  v = 14'd13090;  6'd5:  v = 14'd12740;
            6'd6:  v = 14'd12420;  6'd7:  v = 14'd12110;  6'd8:  v = 14'd11810;
            6'd9:  v = 14'd11530;  6'd10: v = 14'd11260;  6'd11: v = 14'd11010;
            6'd12: v = 14'd10770;  6'd13: v = 14'd10530;  6'd14: v = 14'd10300;
            6'd15: v = 14'd10080;  6'd16: v = 14'd9860;   6'd17: v = 14'd9660;
            6'd18: v = 14'd9460;   6'd19: v = 14'd9270;   6'd20: v = 14'd9080;
            6'd21: v = 14'd8900;   6'd22: v = 14'd8730;   6'd23: v = 14'd8570;
            6'd24: v = 14'd8410;   6'd25: v = 14'd8250;   6'd26: v = 14'd8110;
            6'd27: v = 14'd7960;   6'd28: v = 14'd7820;   6'd29: v = 14'd7690;
            6'd30: v = 14'd7560;   6'd31: v = 14'd7430;   6'd32: v = 14'd7300;
            6'd33: v = 14'd7180;   6'd34: v = 14'd7070;   6'd35: v = 14'd6950;
            6'd36: v = 14'd6840;   6'd37: v = 14'd6730;   6'd38: v = 14'd6630;
            6'd39: v = 14'd6530;   6'd40: v = 14'd6410;
            default: v = 14'd6410;
        endcase
        return v;
    endfunction

    // Water vapor pressure in 0.01 hPa per whole degC
    function automatic logic [12:0] vap_lookup(input logic [5:0] idx);
        logic [12:0] v;
        case (idx)
            6'd0:  v = 13'd611;   6'd1:  v = 13'd657;   6'd2:  v = 13'd706;
            6'd3:  v = 13'd758;   6'd4:  v = 13'd813;   6'd5:  v = 13'd872;
            6'd6:  v = 13'd935;   6'd7:  v = 13'd1002;  6'd8:  v = 13'd1073;
            6'd9:  v = 13'd1148;  6'd10: v = 13'd1228;  6'd11: v = 13'd1313;
            6'd12: v = 13'd1402;  6'd13: v = 13'd1498;  6'd14: v = 13'd1598;
            6'd15: v = 13'd1705;  6'd16: v = 13'd1818;  6'd17: v = 13'd1938;
            6'd18: v = 13'd2064;  6'd19: v = 13'd2197;  6'd20: v = 13'd2338;
            6'd21: v = 13'd2487;  6'd22: v = 13'd2644;  6'd23: v = 13'd2810;
            6'd24: v = 13'd2984;  6'd25: v = 13'd3169;  6'd26: v = 13'd3362;
            6'd27: v = 13'd3567;  6'd28: v = 13'd3781;  6'd29: v = 13'd4007;
            6'd30: v = 13'd4245;  6'd31: v = 13'd4495;  6'd32: v = 13'd4757;
            6'd33: v = 13'd5033;  6'd34: v = 13'd5323;  6'd35: v = 13'd5627;
            6'd36: v = 13'd5946;  6'd37: v = 13'd6280;  6'd38: v = 13'd6630;
            6'd39: v = 13'd6998;  6'd40: v = 13'd7382;
            default: v = 13'd7382;
        endcase
        return v;
    endfunction

endpackage

[design/docr_div.sv]
// Shared restoring divider, one quotient bit per clock.
// Depends on docr_pkg for operand widths.
module docr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [docr_pkg::DIV_NW-1:0]   num,
    input  logic [docr_pkg::DIV_DW-1:0]   den,
    output logic                          done,
    output logic [docr_pkg::DIV_NW-1:0]   quo
);
    import docr_pkg::*;

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_DW:0]   shifted;
    logic [DIV_DW+1:0] diff;
    logic              ge;

    // One trial subtraction per step
    assign shifted = {rem_reg, quo_reg[DIV_NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~diff[DIV_DW+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = DIV_CW'(DIV_NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[design/docr_dp.sv]
// Datapath: configuration registers, sample accumulator, table
// interpolation, compensation arithmetic and output register.
// Depends on docr_pkg and docr_div.
module docr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  docr_pkg::cmd_t      cmd,
    output docr_pkg::sts_t      sts,
    input  logic [15:0]         sample,
    input  logic [14:0]         temperature,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [18:0]         cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [19:0]         dissolved_oxygen,
    output logic [15:0]         average_sample,
    output logic [1:0]          status
);
    import docr_pkg::*;

    // Configuration
    logic        cal_reg;
    logic [18:0] smv_reg;
    logic [11:0] ctemp_reg;
    logic [16:0] air_reg;
    logic [7:0]  avgcnt_reg;

    // Accumulation
    logic signed [23:0] sum_reg, sum_add, hold_reg;
    logic [7:0]         taken_reg, taken_inc, need, n_reg;
    logic signed [14:0] temp_reg;
    logic [23:0]        mag;
    logic               neg;

    // Compensation
    logic               t_ok, air_ok;
    logic signed [15:0] t_diff;
    logic signed [22:0] vslope;
    status_t            stat;
    logic [24:0]        lo_prod;
    logic [5:0]         lo_reg, up_idx;
    logic [6:0]         frac_reg;
    logic [11:0]        frac_full;
    logic [13:0]        s_lo_reg, s_up_reg;
    logic [12:0]        v_lo_reg, v_up_reg;
    logic signed [14:0] s_dif;
    logic signed [13:0] v_dif;
    logic signed [22:0] s100_full;
    logic signed [20:0] vp_full;
    logic [20:0]        s100_reg;
    logic [19:0]        vp_reg;
    logic [23:0]        dry_loc_reg, dry_sea_reg;
    logic [31:0]        den2_reg;
    logic [27:0]        nv_prod;
    logic [23:0]        mul_a;
    logic [20:0]        mul_b;
    logic [44:0]        mul_p, prod_reg;
    logic [20:0]        sat_reg;
    logic [15:0]        avg_reg;
    logic signed [19:0] dov_reg, dov_val;
    logic [16:0]        avg_q;

    // Divider
    logic [DIV_NW-1:0]  div_num, div_quo;
    logic [DIV_DW-1:0]  div_den;
    logic               div_done;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [19:0]        out_dov_reg;
    logic [15:0]        out_avg_reg;
    logic [1:0]         out_stat_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg    <= 1'b0;
            smv_reg    <= 19'd100;
            ctemp_reg  <= 12'd0;
            air_reg    <= 17'd101325;
            avgcnt_reg <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_CALIBRATED:     cal_reg    <= cfg_wdata[0];
                REG_SAT_MILLIVOLTS: smv_reg    <= cfg_wdata;
                REG_CAL_TEMP:       ctemp_reg  <= cfg_wdata[11:0];
                REG_AIR_PRESSURE:   air_reg    <= cfg_wdata[16:0];
                REG_AVERAGE_COUNT:  avgcnt_reg <= cfg_wdata[7:0];
                default:            ;
            endcase
        end
    end

    // Group length and end detection
    assign need      = (avgcnt_reg == 8'd0) ? 8'd1 :
                       ((avgcnt_reg > 8'(MAX_AVERAGE)) ? 8'(MAX_AVERAGE) : avgcnt_reg);
    assign taken_inc = taken_reg + 8'd1;
    assign sum_add   = sum_reg + 24'(signed'(sample));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (sts.grp_end)
            begin
                sum_reg   <= '0;
                taken_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_add;
                taken_reg <= taken_inc;
            end
        end
    end

    // Group snapshot for the result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            temp_reg <= signed'(temperature);
            hold_reg <= sum_add;
            n_reg    <= taken_inc;
        end
    end

    assign neg = hold_reg[23];
    assign mag = neg ? 24'(-hold_reg) : 24'(hold_reg);

    // Status and probe voltage at saturation
    assign t_ok   = !temp_reg[14] && (temp_reg <= 15'(TEMP_MAX));
    assign air_ok = (air_reg >= 17'(AIR_MIN)) && (air_reg <= 17'(AIR_MAX));
    assign t_diff = 16'(temp_reg) - signed'({4'b0000, ctemp_reg});
    assign vslope = signed'({4'b0000, smv_reg}) + 23'(t_diff) * 23'(SLOPE_PER_DEG);

    always_comb
    begin
        if (!cal_reg)
            stat = STAT_NO_CAL;
        else if (!t_ok || !air_ok)
            stat = STAT_RANGE;
        else if (vslope <= 23'sd0)
            stat = STAT_SLOPE;
        else
            stat = STAT_OK;
    end

    // Whole-degree index by reciprocal multiply, then remainder
    assign lo_prod   = temp_reg[11:0] * RECIP_100;
    assign up_idx    = (lo_reg < 6'(TABLE_LAST)) ? lo_reg + 6'd1 : lo_reg;
    assign frac_full = temp_reg[11:0] - 12'(lo_reg * 7'd100);

    // Linear interpolation in 0.01 table units
    assign s_dif     = signed'({1'b0, s_up_reg}) - signed'({1'b0, s_lo_reg});
    assign v_dif     = signed'({1'b0, v_up_reg}) - signed'({1'b0, v_lo_reg});
    assign s100_full = signed'({9'd0, s_lo_reg}) * 23'sd100
                     + signed'({16'd0, frac_reg}) * 23'(s_dif);
    assign vp_full   = signed'({8'd0, v_lo_reg}) * 21'sd100
                     + signed'({14'd0, frac_reg}) * 21'(v_dif);

    // n times slope voltage
    assign nv_prod = n_reg * vslope[19:0];

    // Shared multiplier: pressure scaling, then sum times saturation
    assign mul_a = cmd.ld_mul3 ? mag : dry_loc_reg;
    assign mul_b = cmd.ld_mul3 ? sat_reg : s100_reg;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_lo)
            lo_reg <= lo_prod[RECIP_SHFT+5:RECIP_SHFT];
        if (cmd.ld_frac)
        begin
            frac_reg <= frac_full[6:0];
            s_lo_reg <= sat_lookup(lo_reg);
            s_up_reg <= sat_lookup(up_idx);
            v_lo_reg <= vap_lookup(lo_reg);
            v_up_reg <= vap_lookup(up_idx);
        end
        if (cmd.ld_interp)
        begin
            s100_reg <= s100_full[20:0];
            vp_reg   <= vp_full[19:0];
        end
        if (cmd.ld_dry)
        begin
            dry_loc_reg <= 24'(air_reg) * 24'd100 - 24'(vp_reg);
            dry_sea_reg <= SEA_LEVEL_P100 - 24'(vp_reg);
            den2_reg    <= {1'b0, nv_prod, 3'b000};
        end
        if (cmd.ld_mul || cmd.ld_mul3)
            prod_reg <= mul_p;
        if (cmd.ld_sat)
            sat_reg <= div_quo[20:0];
        if (cmd.ld_avg)
            avg_reg <= avg_q[15:0];
        if (cmd.ld_do)
            dov_reg <= dov_val;
    end

    // Divider operands, each with half the divisor for rounding
    always_comb
    begin
        case (cmd.div_sel)
            DIV_AVG:
            begin
                div_num = DIV_NW'(mag) + DIV_NW'(n_reg >> 1);
                div_den = DIV_DW'(n_reg);
            end
            DIV_SAT:
            begin
                div_num = DIV_NW'(prod_reg) + DIV_NW'(dry_sea_reg >> 1);
                div_den = DIV_DW'(dry_sea_reg);
            end
            DIV_DO:
            begin
                div_num = DIV_NW'(prod_reg) + DIV_NW'(den2_reg >> 1);
                div_den = den2_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    docr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Signed rounding and saturation of quotients
    assign avg_q = neg ? 17'(-div_quo[16:0]) : div_quo[16:0];

    always_comb
    begin
        if (!neg)
            dov_val = (div_quo > DO_POS_LIM) ? 20'sd524287 : signed'(div_quo[19:0]);
        else if (div_quo > DO_NEG_LIM)
            dov_val = -20'sd524288;
        else
            dov_val = 20'(-signed'({1'b0, div_quo[19:0]}));
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.ld_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_dov_reg  <= (stat == STAT_OK) ? dov_reg : 20'sd0;
            out_avg_reg  <= avg_reg;
            out_stat_reg <= stat;
        end
    end

    // Status to controller
    assign sts.grp_end  = (taken_inc >= need);
    assign sts.stat_ok  = (stat == STAT_OK);
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid        = out_valid_reg;
    assign dissolved_oxygen = out_dov_reg;
    assign average_sample   = out_avg_reg;
    assign status           = out_stat_reg;

endmodule

[design/docr_ctrl.sv]
// Controller FSM sequencing accumulation, divisions and the result load.
// Depends on docr_pkg.
module docr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  docr_pkg::sts_t  sts,
    output docr_pkg::cmd_t  cmd
);
    import docr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && sts.grp_end)
                    state_next = ST_AVG;
            ST_AVG:      state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:
                if (sts.div_done)
                    state_next = sts.stat_ok ? ST_LO : ST_DONE;
            ST_LO:       state_next = ST_FRAC;
            ST_FRAC:     state_next = ST_INTERP;
            ST_INTERP:   state_next = ST_DRY;
            ST_DRY:      state_next = ST_MUL;
            ST_MUL:      state_next = ST_SAT;
            ST_SAT:      state_next = ST_SAT_WAIT;
            ST_SAT_WAIT:
                if (sts.div_done)
                    state_next = ST_MUL3;
            ST_MUL3:     state_next = ST_DOV;
            ST_DOV:      state_next = ST_DOV_WAIT;
            ST_DOV_WAIT:
                if (sts.div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = DIV_AVG;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_AVG:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_AVG;
            end
            ST_AVG_WAIT: cmd.ld_avg    = sts.div_done;
            ST_LO:       cmd.ld_lo     = 1'b1;
            ST_FRAC:     cmd.ld_frac   = 1'b1;
            ST_INTERP:   cmd.ld_interp = 1'b1;
            ST_DRY:      cmd.ld_dry    = 1'b1;
            ST_MUL:      cmd.ld_mul    = 1'b1;
            ST_SAT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SAT;
            end
            ST_SAT_WAIT: cmd.ld_sat    = sts.div_done;
            ST_MUL3:     cmd.ld_mul3   = 1'b1;
            ST_DOV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DO;
            end
            ST_DOV_WAIT: cmd.ld_do     = sts.div_done;
            ST_DONE:     cmd.ld_out    = !sts.out_busy;
            default:     ;
        endcase
    end

endmodule

[design/dissolved_oxygen_compensated_reading.sv]
// Top level of the dissolved-oxygen compensated reading block.
// Instantiates docr_ctrl and docr_dp; types from docr_pkg.
//
//  channel | direction | transaction
//  s_*     | in        | one probe sample with water temperature
//  m_*     | out       | one compensated reading per completed group
//  cfg_*   | in        | register write, no read-back
//
// A sample that does not close its group leaves the controller idle, ready
// for the next. The closing sample is followed by the averaging division
// and, unless the status is an error, two more passes through the shared
// bit-serial divider; no sample is taken meanwhile, nor while a finished
// reading waits for the output register. The result waits in an output
// register, so accumulation of the next group goes on while m_tready is
// low. Reset clears the accumulator and restores the register defaults.
module dissolved_oxygen_compensated_reading (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample, [30:16] temperature, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [19:0] dissolved_oxygen, [35:20] average_sample
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [18:0] cfg_wdata
);
    import docr_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [19:0] dov;
    logic [15:0] avg;

    docr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    docr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .sample           (s_tdata[15:0]),
        .temperature      (s_tdata[30:16]),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .dissolved_oxygen (dov),
        .average_sample   (avg),
        .status           (m_tuser)
    );

    assign m_tdata = {4'b0000, avg, dov};

endmodule
